@@ rtl/pse_pkg.sv @@
// shared constants, command, operator and status codes for the postfix stack evaluator
package pse_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 64;

    // field widths fixed by the item format
    localparam int CMD_W     = 2;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 6;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPLY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd2;

    // operator codes
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;
    localparam logic [OP_W-1:0] OP_DIV = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_DIV0  = 2'd3;

endpackage

@@ rtl/pse_stack_ram.sv @@
// single port write, single port read stack memory with registered read data
module pse_stack_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/pse_mul.sv @@
// 64 by 64 wrapping multiplier built from one shared 32 by 32 multiplier reused for three partial products
module pse_mul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pse_pkg::DATA_W-1:0]  op_a,
    input  logic [pse_pkg::DATA_W-1:0]  op_b,
    output logic                        done,
    output logic [pse_pkg::DATA_W-1:0]  product
);

    localparam int HALF_W = pse_pkg::DATA_W / 2;

    logic                       busy_reg, busy_next;
    logic [1:0]                 phase_reg, phase_next;
    logic                       done_reg, done_next;
    logic [pse_pkg::DATA_W-1:0] a_reg, a_next;
    logic [pse_pkg::DATA_W-1:0] b_reg, b_next;
    logic [pse_pkg::DATA_W-1:0] prod_reg, prod_next;
    logic [pse_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic [HALF_W-1:0]          mul_x, mul_y;
    logic [pse_pkg::DATA_W-1:0] mul_p;

    // operand select: low by low, low by high, high by low
    always_comb begin
        case (phase_reg)
            2'd1: begin
                mul_x = a_reg[HALF_W-1:0];
                mul_y = b_reg[pse_pkg::DATA_W-1:HALF_W];
            end
            2'd2: begin
                mul_x = a_reg[pse_pkg::DATA_W-1:HALF_W];
                mul_y = b_reg[HALF_W-1:0];
            end
            default: begin
                mul_x = a_reg[HALF_W-1:0];
                mul_y = b_reg[HALF_W-1:0];
            end
        endcase
    end

    assign mul_p = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};

    // partial product register, then accumulate it in the next phase
    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        if (start) begin
            busy_next  = 1'b1;
            phase_next = 2'd0;
            a_next     = op_a;
            b_next     = op_b;
        end else if (busy_reg) begin
            prod_next  = mul_p;
            phase_next = phase_reg + 2'd1;
            if (phase_reg == 2'd1) begin
                acc_next = prod_reg;
            end else if (phase_reg != 2'd0) begin
                acc_next = acc_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
            end
            if (phase_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ rtl/pse_div.sv @@
// signed truncating divider, restoring radix-2, one quotient bit per cycle
module pse_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pse_pkg::DATA_W-1:0]  dividend,
    input  logic [pse_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [pse_pkg::DATA_W-1:0]  quotient
);

    localparam int DW     = pse_pkg::DATA_W;
    localparam int STEP_W = $clog2(DW);

    logic              busy_reg, busy_next;
    logic              fix_reg, fix_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic [DW-1:0]     den_reg, den_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     quo_reg, quo_next;
    logic [DW-1:0]     q_reg, q_next;
    logic [DW:0]       shifted;
    logic [DW:0]       trial;

    // one restoring step
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        fix_next  = 1'b0;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        q_next    = q_reg;
        if (start) begin
            // magnitudes and sign of the quotient
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = dividend[DW-1] ^ divisor[DW-1];
            quo_next  = dividend[DW-1] ? (DW'(0) - dividend) : dividend;
            den_next  = divisor[DW-1] ? (DW'(0) - divisor) : divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (!trial[DW]) begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = shifted[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DW - 1)) begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end else if (fix_reg) begin
            // restore the sign
            q_next    = neg_reg ? (DW'(0) - quo_reg) : quo_reg;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        neg_reg <= neg_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ rtl/postfix_stack_evaluator_core.sv @@
// postfix stack evaluator top level: command sequencer around the stack memory
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------------------
//  s_       | in  | s_valid/s_ready  | s_cmd[1:0], s_value[63:0], s_operator_code[1:0]
//  m_       | out | m_valid/m_ready  | m_result_value[63:0], m_entries_after[5:0],
//           |     |                  | m_status[1:0]
//
// one item at a time; push, reserved code or short-stack error finish directly, pop
// reads the top, divide by zero reads both operands, add and subtract write back,
// multiply waits for three 32x32 partial products, divide for the divider
// (one quotient bit per cycle plus sign fix); two stack reads share the one read port.
// reset (synchronous, aresetn low) empties the stack; memory contents are not cleared.
// a result waiting on m_ready does not block the next item, only the finish of its
// successor.
module postfix_stack_evaluator_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [pse_pkg::CMD_W-1:0]              s_cmd,
    input  logic signed [pse_pkg::DATA_W-1:0]      s_value,
    input  logic [pse_pkg::OP_W-1:0]               s_operator_code,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [pse_pkg::DATA_W-1:0]      m_result_value,
    output logic [pse_pkg::ENTRIES_W-1:0]          m_entries_after,
    output logic [pse_pkg::STATUS_W-1:0]           m_status
);

    localparam int DW = pse_pkg::DATA_W;
    localparam int AW = pse_pkg::ADDR_W;
    localparam int CW = pse_pkg::CNT_W;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_READ_TOP  = 6'b000010,
        ST_READ_NEXT = 6'b000100,
        ST_ARITH     = 6'b001000,
        ST_WRITE     = 6'b010000,
        ST_FINISH    = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [pse_pkg::CMD_W-1:0]       cmd_reg, cmd_next;
    logic [pse_pkg::OP_W-1:0]        op_reg, op_next;
    logic [DW-1:0]                   right_reg, right_next;
    logic [DW-1:0]                   res_reg, res_next;
    logic [pse_pkg::STATUS_W-1:0]    stat_reg, stat_next;
    logic                            m_valid_reg, m_valid_next;
    logic [DW-1:0]                   m_result_reg, m_result_next;
    logic [pse_pkg::ENTRIES_W-1:0]   m_entries_reg, m_entries_next;
    logic [pse_pkg::STATUS_W-1:0]    m_status_reg, m_status_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] below_addr;

    logic          mul_start, mul_done;
    logic [DW-1:0] mul_product;
    logic          div_start, div_done;
    logic [DW-1:0] div_quotient;

    // stack memory
    pse_stack_ram #(
        .DEPTH (pse_pkg::STACK_DEPTH),
        .WIDTH (DW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // arithmetic units
    pse_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (ram_rdata),
        .op_b    (right_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    pse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (ram_rdata),
        .divisor  (right_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign top_addr   = AW'(cnt_reg - CW'(1));
    assign below_addr = AW'(cnt_reg - CW'(2));

    // sequencer; each access to the memory happens in its own state, so a read
    // never overlaps a write to the same entry
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        op_next        = op_reg;
        right_next     = right_reg;
        res_next       = res_reg;
        stat_next      = stat_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_result_next  = m_result_reg;
        m_entries_next = m_entries_reg;
        m_status_next  = m_status_reg;
        ram_we         = 1'b0;
        ram_waddr      = below_addr;
        ram_wdata      = res_reg;
        ram_raddr      = top_addr;
        mul_start      = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    op_next    = s_operator_code;
                    res_next   = '0;
                    stat_next  = pse_pkg::STAT_OK;
                    state_next = ST_FINISH;
                    case (s_cmd)
                        pse_pkg::CMD_PUSH: begin
                            if (cnt_reg >= CW'(pse_pkg::STACK_DEPTH)) begin
                                stat_next = pse_pkg::STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(cnt_reg);
                                ram_wdata = s_value;
                                cnt_next  = cnt_reg + CW'(1);
                            end
                        end
                        pse_pkg::CMD_APPLY: begin
                            if (cnt_reg < CW'(2)) begin
                                stat_next = pse_pkg::STAT_EMPTY;
                            end else begin
                                state_next = ST_READ_TOP;
                            end
                        end
                        pse_pkg::CMD_POP: begin
                            if (cnt_reg == '0) begin
                                stat_next = pse_pkg::STAT_EMPTY;
                            end else begin
                                state_next = ST_READ_TOP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ_TOP: begin
                if (cmd_reg == pse_pkg::CMD_POP) begin
                    res_next   = ram_rdata;
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = ST_FINISH;
                end else begin
                    right_next = ram_rdata;
                    ram_raddr  = below_addr;
                    state_next = ST_READ_NEXT;
                end
            end
            ST_READ_NEXT: begin
                case (op_reg)
                    pse_pkg::OP_ADD: begin
                        res_next   = ram_rdata + right_reg;
                        state_next = ST_WRITE;
                    end
                    pse_pkg::OP_SUB: begin
                        res_next   = ram_rdata - right_reg;
                        state_next = ST_WRITE;
                    end
                    pse_pkg::OP_MUL: begin
                        mul_start  = 1'b1;
                        state_next = ST_ARITH;
                    end
                    default: begin
                        if (right_reg == '0) begin
                            stat_next  = pse_pkg::STAT_DIV0;
                            state_next = ST_FINISH;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_ARITH;
                        end
                    end
                endcase
            end
            ST_ARITH: begin
                if (mul_done) begin
                    res_next   = mul_product;
                    state_next = ST_WRITE;
                end else if (div_done) begin
                    res_next   = div_quotient;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                ram_we     = 1'b1;
                cnt_next   = cnt_reg - CW'(1);
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_result_next  = res_reg;
                    m_entries_next = pse_pkg::ENTRIES_W'(cnt_reg);
                    m_status_next  = stat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg       <= cmd_next;
        op_reg        <= op_next;
        right_reg     <= right_next;
        res_reg       <= res_next;
        stat_reg      <= stat_next;
        m_result_reg  <= m_result_next;
        m_entries_reg <= m_entries_next;
        m_status_reg  <= m_status_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_result_value  = m_result_reg;
    assign m_entries_after = m_entries_reg;
    assign m_status        = m_status_reg;

    // stack count never passes the capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(pse_pkg::STACK_DEPTH))
        else $error("stack count above capacity");

    // a full report only comes from a full stack
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && stat_reg == pse_pkg::STAT_FULL)
        |-> cnt_reg == CW'(pse_pkg::STACK_DEPTH))
        else $error("full status with room left");

    // divide by zero leaves both operands on the stack
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && stat_reg == pse_pkg::STAT_DIV0)
        |-> cnt_reg >= CW'(2))
        else $error("divide by zero lost operands");

    // arithmetic units finish only while the sequencer waits for them
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_done || div_done) |-> state_reg == ST_ARITH)
        else $error("unit result outside arith wait");

    // the stack memory is written only on push acceptance or result write-back
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_WRITE || (state_reg == ST_IDLE && s_valid)))
        else $error("unexpected stack write");

endmodule

@@ verif/stack_eval_checker.sv @@
// result checker for the postfix stack evaluator: mirrors the stack and compares every result
module stack_eval_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [pse_pkg::CMD_W-1:0]           s_cmd,
    input  logic signed [pse_pkg::DATA_W-1:0]   s_value,
    input  logic [pse_pkg::OP_W-1:0]            s_operator_code,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [pse_pkg::DATA_W-1:0]   m_result_value,
    input  logic [pse_pkg::ENTRIES_W-1:0]       m_entries_after,
    input  logic [pse_pkg::STATUS_W-1:0]        m_status,
    output int                                  fail_count,
    output int                                  pending_count,
    output int                                  checked_count,
    output int                                  flagged_count
);

    typedef struct packed {
        logic [pse_pkg::DATA_W-1:0]    value;
        logic [pse_pkg::ENTRIES_W-1:0] entries;
        logic [pse_pkg::STATUS_W-1:0]  status;
    } stack_outcome_t;

    // mirror of the stack contents and depth
    logic [pse_pkg::DATA_W-1:0] stack_mirror [pse_pkg::STACK_DEPTH];
    int                         mirror_depth;
    stack_outcome_t             expected_outcomes [$];

    // apply one command to the mirror and return the result it must produce
    function automatic stack_outcome_t predict_outcome(
        input logic [pse_pkg::CMD_W-1:0]  cmd,
        input logic [pse_pkg::DATA_W-1:0] val,
        input logic [pse_pkg::OP_W-1:0]   op);
        logic [pse_pkg::DATA_W-1:0] lhs;
        logic [pse_pkg::DATA_W-1:0] rhs;
        logic [pse_pkg::DATA_W-1:0] mag_l;
        logic [pse_pkg::DATA_W-1:0] mag_r;
        logic [pse_pkg::DATA_W-1:0] quo;
        stack_outcome_t             res;
        res.value  = '0;
        res.status = pse_pkg::STAT_OK;
        case (cmd)
            pse_pkg::CMD_PUSH: begin
                if (mirror_depth >= pse_pkg::STACK_DEPTH) begin
                    res.status = pse_pkg::STAT_FULL;
                end else begin
                    stack_mirror[mirror_depth] = val;
                    mirror_depth++;
                end
            end
            pse_pkg::CMD_APPLY: begin
                if (mirror_depth < 2) begin
                    res.status = pse_pkg::STAT_EMPTY;
                end else begin
                    rhs = stack_mirror[mirror_depth-1];
                    lhs = stack_mirror[mirror_depth-2];
                    case (op)
                        pse_pkg::OP_ADD: res.value = lhs + rhs;
                        pse_pkg::OP_SUB: res.value = lhs - rhs;
                        pse_pkg::OP_MUL: res.value = lhs * rhs;
                        default: begin
                            // truncating divide on magnitudes, sign fixed afterwards
                            if (rhs == '0) begin
                                res.status = pse_pkg::STAT_DIV0;
                            end else begin
                                mag_l = lhs[pse_pkg::DATA_W-1] ? -lhs : lhs;
                                mag_r = rhs[pse_pkg::DATA_W-1] ? -rhs : rhs;
                                quo   = mag_l / mag_r;
                                res.value = (lhs[pse_pkg::DATA_W-1] ^ rhs[pse_pkg::DATA_W-1])
                                            ? -quo : quo;
                            end
                        end
                    endcase
                    if (res.status == pse_pkg::STAT_OK) begin
                        mirror_depth--;
                        stack_mirror[mirror_depth-1] = res.value;
                    end
                end
            end
            pse_pkg::CMD_POP: begin
                if (mirror_depth == 0) begin
                    res.status = pse_pkg::STAT_EMPTY;
                end else begin
                    mirror_depth--;
                    res.value = stack_mirror[mirror_depth];
                end
            end
            default: ;
        endcase
        res.entries = pse_pkg::ENTRIES_W'(mirror_depth);
        return res;
    endfunction

    // compare finished results, then log newly accepted items
    always @(posedge aclk) begin
        stack_outcome_t exp_out;
        if (!aresetn) begin
            expected_outcomes.delete();
            mirror_depth  = 0;
            fail_count    = 0;
            checked_count = 0;
            flagged_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result arrived with no item outstanding");
                    fail_count++;
                end else begin
                    exp_out = expected_outcomes.pop_front();
                    checked_count++;
                    if (exp_out.status != pse_pkg::STAT_OK)
                        flagged_count++;
                    if (m_result_value !== exp_out.value) begin
                        $error("m_result_value: expected %0d, got %0d",
                               $signed(exp_out.value), m_result_value);
                        fail_count++;
                    end
                    if (m_entries_after !== exp_out.entries) begin
                        $error("m_entries_after: expected %0d, got %0d",
                               exp_out.entries, m_entries_after);
                        fail_count++;
                    end
                    if (m_status !== exp_out.status) begin
                        $error("m_status: expected %0d, got %0d",
                               exp_out.status, m_status);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_outcomes.push_back(predict_outcome(s_cmd, s_value, s_operator_code));
        end
        pending_count = expected_outcomes.size();
    end

endmodule

@@ verif/testbench.sv @@
// stimulus, clocking and verdict for the postfix stack evaluator
module testbench;

    localparam logic [pse_pkg::CMD_W-1:0]         CMD_RESERVED   = 2'd3;
    localparam logic signed [pse_pkg::DATA_W-1:0] VAL_MAX        = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [pse_pkg::DATA_W-1:0] VAL_MIN        = 64'sh8000_0000_0000_0000;
    localparam int                                LONG_HOLD      = 250;
    localparam int                                WATCHDOG_LIMIT = 3000;
    localparam int                                IDLE_ITEMS     = 1050;
    localparam int                                TOTAL_ITEMS    = 1200;

    logic                               aclk            = 1'b0;
    logic                               aresetn         = 1'b0;
    logic                               s_valid         = 1'b0;
    logic                               s_ready;
    logic [pse_pkg::CMD_W-1:0]          s_cmd           = pse_pkg::CMD_PUSH;
    logic signed [pse_pkg::DATA_W-1:0]  s_value         = '0;
    logic [pse_pkg::OP_W-1:0]           s_operator_code = pse_pkg::OP_ADD;
    logic                               m_valid;
    logic                               m_ready         = 1'b0;
    logic signed [pse_pkg::DATA_W-1:0]  m_result_value;
    logic [pse_pkg::ENTRIES_W-1:0]      m_entries_after;
    logic [pse_pkg::STATUS_W-1:0]       m_status;

    int fail_count;
    int pending_count;
    int checked_count;
    int flagged_count;

    int   items_sent     = 0;
    int   reserved_sent  = 0;
    int   stalled_cycles = 0;
    int   sink_hold_left = 0;
    logic idle_on        = 1'b1;
    logic long_hold_req  = 1'b0;
    logic long_hold_done = 1'b0;

    always #10 aclk = ~aclk;

    postfix_stack_evaluator_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_value         (s_value),
        .s_operator_code (s_operator_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_entries_after (m_entries_after),
        .m_status        (m_status)
    );

    stack_eval_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_value         (s_value),
        .s_operator_code (s_operator_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_entries_after (m_entries_after),
        .m_status        (m_status),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .checked_count   (checked_count),
        .flagged_count   (flagged_count)
    );

    // result side: random stall bursts plus one long hold-off on request
    always @(posedge aclk) begin
        if (sink_hold_left > 0) begin
            sink_hold_left <= sink_hold_left - 1;
            m_ready        <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            sink_hold_left <= LONG_HOLD - 1;
            long_hold_done <= 1'b1;
            m_ready        <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_hold_left <= $urandom_range(0, 8);
            m_ready        <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog: cycles with no handshake on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [pse_pkg::DATA_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // operand mix: extremes, small signed values and full-width noise
    function automatic logic [pse_pkg::DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return '1;
            4: return 64'd1;
            5, 6: return 64'($signed($urandom_range(0, 2000)) - 1000);
            default: return random_word();
        endcase
    endfunction

    // offer one item, hold it until accepted, then maybe go quiet for a burst
    task automatic send_cmd(input logic [pse_pkg::CMD_W-1:0] cmd,
                            input logic [pse_pkg::DATA_W-1:0] val,
                            input logic [pse_pkg::OP_W-1:0] op);
        s_cmd           <= cmd;
        s_value         <= val;
        s_operator_code <= op;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_RESERVED)
            reserved_sent++;
        else
            items_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // stop offering and wait until every outstanding result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_count == 0);
        @(posedge aclk);
    endtask

    // well-formed postfix expression with random operators, result popped
    task automatic run_expression();
        int operands;
        int held;
        int pushed;
        operands = $urandom_range(2, 6);
        held     = 0;
        pushed   = 0;
        while (pushed < operands || held > 1) begin
            if (held < 2 || (pushed < operands && $urandom_range(0, 1) == 1)) begin
                send_cmd(pse_pkg::CMD_PUSH, pick_operand(), 2'($urandom_range(0, 3)));
                pushed++;
                held++;
            end else begin
                send_cmd(pse_pkg::CMD_APPLY, random_word(), 2'($urandom_range(0, 3)));
                held--;
            end
        end
        send_cmd(pse_pkg::CMD_POP, random_word(), 2'($urandom_range(0, 3)));
    endtask

    // push past full, then pop past empty
    task automatic run_fill_drain();
        repeat (pse_pkg::STACK_DEPTH + 2)
            send_cmd(pse_pkg::CMD_PUSH, pick_operand(), 2'($urandom_range(0, 3)));
        repeat (pse_pkg::STACK_DEPTH + 3)
            send_cmd(pse_pkg::CMD_POP, random_word(), 2'($urandom_range(0, 3)));
    endtask

    // random mix of sequence shapes until the item count is reached
    task automatic run_random_sequences(input int item_goal);
        int pick;
        while (items_sent < item_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                run_expression();
            end else if (pick < 59) begin
                run_fill_drain();
            end else if (pick < 75) begin
                // division focus: special divisors are likely from the operand mix
                send_cmd(pse_pkg::CMD_PUSH, pick_operand(), 2'($urandom_range(0, 3)));
                send_cmd(pse_pkg::CMD_PUSH, pick_operand(), 2'($urandom_range(0, 3)));
                send_cmd(pse_pkg::CMD_APPLY, random_word(), pse_pkg::OP_DIV);
                send_cmd(pse_pkg::CMD_POP, random_word(), 2'($urandom_range(0, 3)));
            end else begin
                // noise: any command code, any operator
                repeat ($urandom_range(1, 3))
                    send_cmd(2'($urandom_range(0, 3)), pick_operand(),
                             2'($urandom_range(0, 3)));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty stack errors, wraparound, divide cases, reserved code
        send_cmd(pse_pkg::CMD_POP,   '0,      pse_pkg::OP_ADD);
        send_cmd(pse_pkg::CMD_APPLY, '0,      pse_pkg::OP_ADD);
        send_cmd(pse_pkg::CMD_PUSH,  VAL_MAX, pse_pkg::OP_ADD);
        send_cmd(pse_pkg::CMD_APPLY, '0,      pse_pkg::OP_ADD);
        send_cmd(pse_pkg::CMD_PUSH,  64'd1,   pse_pkg::OP_SUB);
        send_cmd(pse_pkg::CMD_APPLY, '1,      pse_pkg::OP_ADD);
        send_cmd(pse_pkg::CMD_PUSH,  '1,      pse_pkg::OP_MUL);
        send_cmd(pse_pkg::CMD_APPLY, '0,      pse_pkg::OP_DIV);
        send_cmd(pse_pkg::CMD_PUSH,  '0,      pse_pkg::OP_DIV);
        send_cmd(pse_pkg::CMD_APPLY, '1,      pse_pkg::OP_DIV);
        send_cmd(pse_pkg::CMD_APPLY, '0,      pse_pkg::OP_MUL);
        send_cmd(pse_pkg::CMD_PUSH,  64'd7,   pse_pkg::OP_ADD);
        send_cmd(pse_pkg::CMD_APPLY, '0,      pse_pkg::OP_SUB);
        send_cmd(pse_pkg::CMD_PUSH,  64'd2,   pse_pkg::OP_ADD);
        send_cmd(pse_pkg::CMD_APPLY, '0,      pse_pkg::OP_DIV);
        send_cmd(pse_pkg::CMD_PUSH,  VAL_MIN, pse_pkg::OP_ADD);
        send_cmd(pse_pkg::CMD_PUSH,  VAL_MIN, pse_pkg::OP_ADD);
        send_cmd(pse_pkg::CMD_APPLY, '0,      pse_pkg::OP_MUL);
        send_cmd(CMD_RESERVED,       VAL_MAX, pse_pkg::OP_DIV);
        send_cmd(pse_pkg::CMD_POP,   '0,      pse_pkg::OP_ADD);
        send_cmd(pse_pkg::CMD_POP,   '0,      pse_pkg::OP_ADD);
        send_cmd(pse_pkg::CMD_POP,   '0,      pse_pkg::OP_ADD);
        run_fill_drain();

        // long result stall while items keep coming, then a full sender pause
        long_hold_req = 1'b1;
        repeat (6) run_expression();
        drain_results();

        run_random_sequences(IDLE_ITEMS);

        // closing stretch with both sides running flat out
        drain_results();
        idle_on = 1'b0;
        run_random_sequences(TOTAL_ITEMS);

        drain_results();
        repeat (100) @(posedge aclk);
        $display("run covered %0d push/apply/pop items and %0d reserved codes",
                 items_sent, reserved_sent);
        $display("%0d results checked, %0d of them flagged full, empty or divide by zero",
                 checked_count, flagged_count);
        if (fail_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pse_pkg.sv
rtl/pse_stack_ram.sv
rtl/pse_mul.sv
rtl/pse_div.sv
rtl/postfix_stack_evaluator_core.sv
verif/stack_eval_checker.sv
verif/testbench.sv
